// ===== design/stable_descending_record_sorter_top_macros.svh =====
// Assertion macros for the stable descending record sorter.
`ifndef STABLE_DESCENDING_RECORD_SORTER_TOP_MACROS_SVH
`define STABLE_DESCENDING_RECORD_SORTER_TOP_MACROS_SVH

// same-cycle implication
`define SDRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorter assertion failed");

// next-cycle implication
`define SDRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorter assertion failed");

`endif

// ===== design/sdrs_pkg.sv =====
// Types and constants shared by the record sorter modules.
`default_nettype none

package sdrs_pkg;

  localparam int unsigned MaxRecords = 16;
  localparam int unsigned IdW        = 34;
  localparam int unsigned ScoreW     = 16;
  localparam int unsigned TagW       = 6;

  typedef struct packed {
    logic [IdW-1:0]    record_id;
    logic [ScoreW-1:0] record_score;
    logic [TagW-1:0]   record_tag;
    logic              last_record;
  } in_t;

  typedef struct packed {
    logic [IdW-1:0]    out_id;
    logic [ScoreW-1:0] out_score;
    logic [TagW-1:0]   out_tag;
    logic              out_last;
    logic              overflow;
  } out_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ScoreW-1:0] score;
    logic [TagW-1:0]   tag;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_cmd_t;

  typedef enum logic {
    StCollect,
    StDrain
  } state_e;

endpackage

`default_nettype wire

// ===== design/sdrs_cell.sv =====
// One slot of the sorting chain: holds a record, takes from either neighbour.
`default_nettype none

module sdrs_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sdrs_pkg::cell_cmd_t cmd_i,
  input  wire logic              key_sel_i,
  input  wire sdrs_pkg::rec_t    new_rec_i,
  input  wire logic              prev_lt_i,
  input  wire logic              prev_valid_i,
  input  wire sdrs_pkg::rec_t    prev_rec_i,
  input  wire logic              next_lt_i,
  input  wire logic              next_valid_i,
  input  wire sdrs_pkg::rec_t    next_rec_i,
  output logic                   valid_o,
  output logic                   lt_o,
  output sdrs_pkg::rec_t         rec_o
);

  logic           valid_q, valid_d;
  sdrs_pkg::rec_t rec_q, rec_d;
  logic           key_lt;

  // empty slots rank below every record; a slot moves back only when it and
  // every slot behind it rank below the new record
  assign key_lt = key_sel_i ? (rec_q.id < new_rec_i.id) : (rec_q.score < new_rec_i.score);
  assign lt_o   = (!valid_q || key_lt) && next_lt_i;

  always_comb begin
    valid_d = valid_q;
    rec_d   = rec_q;
    priority if (cmd_i.shift_out) begin
      valid_d = next_valid_i;
      rec_d   = next_rec_i;
    end else if (cmd_i.insert && lt_o) begin
      if (prev_lt_i) begin
        valid_d = prev_valid_i;
        rec_d   = prev_rec_i;
      end else begin
        valid_d = 1'b1;
        rec_d   = new_rec_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;

endmodule

`default_nettype wire

// ===== design/sdrs_ctrl.sv =====
// Collect/drain sequencer and overflow flag for the record sorter.
`default_nettype none

`include "stable_descending_record_sorter_top_macros.svh"

module sdrs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_last_i,
  input  wire logic                out_stall_i,
  input  wire logic                full_i,
  input  wire logic                head_valid_i,
  input  wire logic                more_i,
  output sdrs_pkg::cell_cmd_t      cmd_o,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output logic                     dropped_o
);

  sdrs_pkg::state_e state_q, state_d;
  logic             dropped_q, dropped_d;

  always_comb begin
    state_d         = state_q;
    dropped_d       = dropped_q;
    cmd_o.insert    = 1'b0;
    cmd_o.shift_out = 1'b0;
    in_stall_o      = 1'b0;
    out_valid_o     = 1'b0;
    unique case (state_q)
      sdrs_pkg::StCollect: begin
        if (in_valid_i) begin
          cmd_o.insert = !full_i;
          if (full_i) begin
            dropped_d = 1'b1;
          end
          if (in_last_i) begin
            state_d = sdrs_pkg::StDrain;
          end
        end
      end
      sdrs_pkg::StDrain: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.shift_out = 1'b1;
          if (!more_i) begin
            state_d   = sdrs_pkg::StCollect;
            dropped_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = sdrs_pkg::StCollect;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sdrs_pkg::StCollect;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dropped_q <= dropped_d;
    end
  end

  assign dropped_o = dropped_q;

  `SDRS_ASSERT_IMP(a_drain_has_head, clk_i, rst_ni, state_q == sdrs_pkg::StDrain, head_valid_i)
  `SDRS_ASSERT_NXT(a_last_starts_drain, clk_i, rst_ni,
                   state_q == sdrs_pkg::StCollect && in_valid_i && in_last_i,
                   state_q == sdrs_pkg::StDrain)
  `SDRS_ASSERT_NXT(a_stall_holds_drain, clk_i, rst_ni,
                   state_q == sdrs_pkg::StDrain && out_stall_i,
                   state_q == sdrs_pkg::StDrain)
  `SDRS_ASSERT_NXT(a_run_end_clears, clk_i, rst_ni,
                   state_q == sdrs_pkg::StDrain && !out_stall_i && !more_i,
                   !dropped_q && !head_valid_i)

endmodule

`default_nettype wire

// ===== design/stable_descending_record_sorter_top.sv =====
// Top level of the stable descending record sorter.
// Records enter one per cycle and are inserted into a chain of MAX_RECORDS
// slots, kept in descending order of score or identifier (key_select), ties in
// arrival order. A record flagged last starts a run: while the output is not
// stalled, the chain shifts one slot per cycle towards the head, giving one result
// per stored record; input is stalled during the run. Records arriving with every
// slot occupied are dropped and flagged as overflow on each result of the run.
`default_nettype none

module stable_descending_record_sorter_top #(
  parameter int unsigned MAX_RECORDS = sdrs_pkg::MaxRecords
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire sdrs_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output sdrs_pkg::out_t     out_data_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_data_i
);

  logic                key_sel_q;
  sdrs_pkg::cell_cmd_t cmd;
  sdrs_pkg::rec_t      new_rec;
  logic                dropped;
  logic                cell_valid [MAX_RECORDS];
  logic                cell_lt    [MAX_RECORDS];
  sdrs_pkg::rec_t      cell_rec   [MAX_RECORDS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_sel_q <= 1'b0;
    end else if (cfg_valid_i) begin
      key_sel_q <= cfg_data_i;
    end
  end

  assign new_rec.id    = in_data_i.record_id;
  assign new_rec.score = in_data_i.record_score;
  assign new_rec.tag   = in_data_i.record_tag;

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic           prev_lt, prev_valid, next_lt, next_valid;
    sdrs_pkg::rec_t prev_rec, next_rec;

    if (i == 0) begin : g_head
      assign prev_lt    = 1'b0;
      assign prev_valid = 1'b0;
      assign prev_rec   = '0;
    end else begin : g_body
      assign prev_lt    = cell_lt[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_rec   = cell_rec[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_lt    = 1'b1;
      assign next_valid = 1'b0;
      assign next_rec   = '0;
    end else begin : g_inner
      assign next_lt    = cell_lt[i+1];
      assign next_valid = cell_valid[i+1];
      assign next_rec   = cell_rec[i+1];
    end

    sdrs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .key_sel_i    (key_sel_q),
      .new_rec_i    (new_rec),
      .prev_lt_i    (prev_lt),
      .prev_valid_i (prev_valid),
      .prev_rec_i   (prev_rec),
      .next_lt_i    (next_lt),
      .next_valid_i (next_valid),
      .next_rec_i   (next_rec),
      .valid_o      (cell_valid[i]),
      .lt_o         (cell_lt[i]),
      .rec_o        (cell_rec[i])
    );
  end

  sdrs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_last_i    (in_data_i.last_record),
    .out_stall_i  (out_stall_i),
    .full_i       (cell_valid[MAX_RECORDS-1]),
    .head_valid_i (cell_valid[0]),
    .more_i       (cell_valid[1]),
    .cmd_o        (cmd),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .dropped_o    (dropped)
  );

  assign out_data_o.out_id    = cell_rec[0].id;
  assign out_data_o.out_score = cell_rec[0].score;
  assign out_data_o.out_tag   = cell_rec[0].tag;
  assign out_data_o.out_last  = !cell_valid[1];
  assign out_data_o.overflow  = dropped;

endmodule

`default_nettype wire
